FILE: sv/vppu_pkg.sv
// Package for the vertex perspective projection unit.
// Holds shared types, codes, the divider latency and the 32-bit saturation helper.
// No dependencies.
`default_nettype none

package vppu_pkg;

  typedef logic signed [31:0] word_t;

  // Input item kinds
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_VP_X      = 2'd0,
    REG_VP_Y      = 2'd1,
    REG_VP_WIDTH  = 2'd2,
    REG_VP_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [14:0] VP_WIDTH_RST  = 15'd1024;
  localparam logic [14:0] VP_HEIGHT_RST = 15'd768;

  // Clip w below 0.0001: w * 10000 < 1.0
  localparam logic signed [45:0] W_TEST_SCALE = 46'sd10000;

  // Divider: one prep stage, one stage per quotient bit, one finish stage
  localparam int DIV_LAT = 34;

  // Clamp a wide signed value into 32 bits
  function automatic word_t sat32(input logic signed [65:0] v);
    word_t res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/vppu_xform.sv
// 4x4 fixed-point matrix times vector, column-major, two register stages.
// Depends on vppu_pkg (sat32).
`default_nettype none

module vppu_xform #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [15:0][31:0] mat,
  input  logic [3:0][31:0]  src,
  output logic [3:0][31:0]  dst
);
  import vppu_pkg::*;

  logic signed [63:0] prod [4][4];
  logic signed [65:0] acc  [4];

  // Stage 1: sixteen products, element (r,c) sits at slot c*4+r
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod[r][c] <= $signed(mat[c*4+r]) * $signed(src[c]);
        end
      end
    end

    // Stage 2: floor each product, sum exactly, clamp
    always_comb begin
      acc[r] = 66'(prod[r][0] >>> FRAC_BITS) + 66'(prod[r][1] >>> FRAC_BITS)
             + 66'(prod[r][2] >>> FRAC_BITS) + 66'(prod[r][3] >>> FRAC_BITS);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dst[r] <= sat32(acc[r]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/vppu_div.sv
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, toward zero, clamped.
// One quotient bit per stage. Depends on vppu_pkg (word_t).
`default_nettype none

module vppu_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  vppu_pkg::word_t num,
  input  vppu_pkg::word_t den,
  output vppu_pkg::word_t quo
);
  import vppu_pkg::*;

  logic [63:0] rem  [33];
  logic [31:0] dv   [33];
  logic [31:0] qb   [33];
  logic        neg  [33];
  logic        big  [33];

  logic [31:0] mag;
  logic [63:0] n64;

  // Prep: magnitude, scaled numerator, quotient-too-large flag
  always_comb begin
    mag = num[31] ? 32'(-num) : 32'(num);
    n64 = {{(32 - FRAC_BITS){1'b0}}, mag, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n64;
      dv[0]  <= den;
      qb[0]  <= '0;
      neg[0] <= num[31];
      big[0] <= n64 >= {den, 32'd0};
    end
  end

  // One bit per stage, MSB first
  for (genvar k = 0; k < 32; k++) begin : g_bit
    logic [63:0] trial;
    assign trial = {32'd0, dv[k]} << (31 - k);

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        big[k+1] <= big[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          qb[k+1]  <= qb[k] | (32'd1 << (31 - k));
        end else begin
          rem[k+1] <= rem[k];
          qb[k+1]  <= qb[k];
        end
      end
    end
  end

  // Finish: sign and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[32]) begin
        quo <= (big[32] || qb[32][31]) ? 32'sh80000000 : word_t'(-qb[32]);
      end else begin
        quo <= (big[32] || qb[32][31]) ? 32'sh7fffffff : word_t'(qb[32]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/vppu_window.sv
// Viewport mapping, depth test, y flip and output register, two stages.
// Depends on vppu_pkg (word_t, sat32).
`default_nettype none

module vppu_window #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            en,
  input  vppu_pkg::word_t nx,
  input  vppu_pkg::word_t ny,
  input  vppu_pkg::word_t nz,
  input  logic            wfail,
  input  logic [15:0]     vp_x,
  input  logic [15:0]     vp_y,
  input  logic [14:0]     vp_w,
  input  logic [14:0]     vp_h,
  output logic            visible,
  output vppu_pkg::word_t screen_x,
  output vppu_pkg::word_t screen_y,
  output logic [16:0]     depth
);
  import vppu_pkg::*;

  logic signed [33:0] one34;
  logic signed [33:0] ox, oy, wz;
  logic signed [15:0] sw, sh;
  logic signed [51:0] sum_x, sum_y;
  logic               z_ok;

  word_t       a_wx, a_wy;
  logic        a_vis;
  logic [16:0] a_wz;

  logic signed [41:0] h42, wy42, sy42;

  // Stage a: origin*2*one + (one + ndc) * size, halved with floor
  always_comb begin
    one34 = 34'sd1 <<< FRAC_BITS;
    ox    = one34 + 34'(nx);
    oy    = one34 + 34'(ny);
    sw    = {1'b0, vp_w};
    sh    = {1'b0, vp_h};
    // operands widened first so the product keeps all 49 bits
    sum_x = (52'($signed(vp_x)) <<< (FRAC_BITS + 1)) + (52'(ox) * 52'(sw));
    sum_y = (52'($signed(vp_y)) <<< (FRAC_BITS + 1)) + (52'(oy) * 52'(sh));
    wz    = (one34 + 34'(nz)) >>> 1;
    z_ok  = !wz[33] && (wz <= one34);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_wx  <= sat32(66'(sum_x >>> 1));
      a_wy  <= sat32(66'(sum_y >>> 1));
      a_vis <= !wfail && z_ok;
      a_wz  <= wz[16:0];
    end
  end

  // Stage b: flip y against the height, zero rejected points
  always_comb begin
    h42  = {27'd0, vp_h};
    wy42 = 42'(a_wy);
    sy42 = (h42 <<< FRAC_BITS) - wy42;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible  <= a_vis;
      screen_x <= a_vis ? a_wx : '0;
      screen_y <= a_vis ? sat32(66'(sy42)) : '0;
      depth    <= a_vis ? a_wz : '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/vertex_perspective_projection_unit.sv
// Top level of the vertex perspective projection unit: coefficient store,
// viewport registers, pipeline control. Depends on vppu_pkg, vppu_xform, vppu_div,
// vppu_window.
//
//  channel | signals                                          | transaction
//  in      | in_valid/in_ready, op, coef_index, coef_value,   | load or project
//          | obj_x, obj_y, obj_z                              |
//  out     | out_valid/out_ready, visible, screen_x/y, depth  | one per project
//  cfg     | cfg_we, cfg_index, cfg_data                      | register write
//
// One transaction per cycle while the output is not stalled; a projected point passes
// through the two matrix stages, the 34-stage divider and the 2 viewport stages.
// Reset clears the coefficient store and all valid bits; the viewport goes to 0, 0, 1024x768.
// A stalled output freezes the whole pipeline and drops in_ready.
// Loads are applied to the modelview half at entry and to the projection half when
// they reach the projection multiply, in order with the points around them.
`default_nettype none

module vertex_perspective_projection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            op,
  input  logic [4:0]      coef_index,
  input  vppu_pkg::word_t coef_value,
  input  vppu_pkg::word_t obj_x,
  input  vppu_pkg::word_t obj_y,
  input  vppu_pkg::word_t obj_z,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            visible,
  output vppu_pkg::word_t screen_x,
  output vppu_pkg::word_t screen_y,
  output logic [16:0]     depth,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import vppu_pkg::*;

  localparam int PIPE_LEN = 2 + 2 + DIV_LAT + 2;

  logic [31:0][31:0] coef_store;
  logic [15:0]       vp_x, vp_y;
  logic [14:0]       vp_w, vp_h;

  logic              adv, in_acc;
  logic [PIPE_LEN-1:0] pv;
  logic [DIV_LAT-1:0]  wf;
  logic [1:0]        ld_v;
  logic [3:0]        ld_idx [2];
  word_t             ld_val [2];

  logic [3:0][31:0]  src1, eye, clip;
  logic signed [45:0] w_scaled;
  logic              wfail_now;
  word_t             nx, ny, nz;

  // Whole pipeline moves unless the output holds a result not taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && in_ready;
  assign out_valid = pv[PIPE_LEN-1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_x <= '0;
      vp_y <= '0;
      vp_w <= VP_WIDTH_RST;
      vp_h <= VP_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VP_X:      vp_x <= cfg_data;
        REG_VP_Y:      vp_y <= cfg_data;
        REG_VP_WIDTH:  vp_w <= cfg_data[14:0];
        REG_VP_HEIGHT: vp_h <= cfg_data[14:0];
        default:       vp_x <= vp_x;
      endcase
    end
  end

  // Valid bits and wfail tags travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= '0;
      ld_v <= '0;
    end else if (adv) begin
      pv   <= {pv[PIPE_LEN-2:0], in_acc && (op_t'(op) == OP_PROJECT)};
      ld_v <= {ld_v[0], in_acc && (op_t'(op) == OP_LOAD) && coef_index[4]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_idx[0] <= coef_index[3:0];
      ld_val[0] <= coef_value;
      ld_idx[1] <= ld_idx[0];
      ld_val[1] <= ld_val[0];
      wf        <= {wf[DIV_LAT-2:0], wfail_now};
    end
  end

  // Coefficient store: modelview written at entry, projection when the load
  // reaches the projection multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_store <= '0;
    end else begin
      if (in_acc && (op_t'(op) == OP_LOAD) && !coef_index[4]) begin
        coef_store[coef_index] <= coef_value;
      end
      if (adv && ld_v[1]) begin
        coef_store[{1'b1, ld_idx[1]}] <= ld_val[1];
      end
    end
  end

  // Object point extended with w = 1.0
  assign src1 = {32'(64'sd1 <<< FRAC_BITS), obj_z, obj_y, obj_x};

  vppu_xform #(.FRAC_BITS(FRAC_BITS)) u_modelview (
    .clk (clk),
    .en  (adv),
    .mat (coef_store[15:0]),
    .src (src1),
    .dst (eye)
  );

  vppu_xform #(.FRAC_BITS(FRAC_BITS)) u_projection (
    .clk (clk),
    .en  (adv),
    .mat (coef_store[31:16]),
    .src (eye),
    .dst (clip)
  );

  // Near test on clip w
  always_comb begin
    w_scaled  = 46'($signed(clip[3])) * W_TEST_SCALE;
    wfail_now = w_scaled < (46'sd1 <<< FRAC_BITS);
  end

  vppu_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk), .en (adv), .num (clip[0]), .den (clip[3]), .quo (nx)
  );
  vppu_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk), .en (adv), .num (clip[1]), .den (clip[3]), .quo (ny)
  );
  vppu_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk (clk), .en (adv), .num (clip[2]), .den (clip[3]), .quo (nz)
  );

  vppu_window #(.FRAC_BITS(FRAC_BITS)) u_window (
    .clk      (clk),
    .en       (adv),
    .nx       (nx),
    .ny       (ny),
    .nz       (nz),
    .wfail    (wf[DIV_LAT-1]),
    .vp_x     (vp_x),
    .vp_y     (vp_y),
    .vp_w     (vp_w),
    .vp_h     (vp_h),
    .visible  (visible),
    .screen_x (screen_x),
    .screen_y (screen_y),
    .depth    (depth)
  );

  // Rejected points carry all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == '0 && screen_y == '0 && depth == '0)
    else $error("rejected point with nonzero fields");

  // Visible depth never exceeds 1.0 in the field
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> 18'(depth) <= (18'd1 << FRAC_BITS))
    else $error("visible depth above one");

  // Output backpressure blocks intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // A modelview load lands in the store at the next edge
  a_mv_load: assert property (@(posedge clk) disable iff (rst)
    in_acc && !op && !coef_index[4] |=>
      coef_store[$past(coef_index)] == $past(coef_value))
    else $error("modelview load not stored");

endmodule

`default_nettype wire

FILE: verif/vertex_perspective_projection_unit_tb.sv
// Self-checking testbench for vertex_perspective_projection_unit.
// Drives coefficient loads and point projections with random idling on both channels,
// predicts every projected point in fixed point and checks each one. Depends on vppu_pkg.
`default_nettype none

class projection_scoreboard;
  typedef struct {
    logic        visible;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [16:0] depth;
  } point_t;

  logic [31:0]       coef_store[32];
  logic signed [15:0] vp_x, vp_y;
  logic [14:0]       vp_w, vp_h;
  point_t            pending[$];
  int                errors;
  int                checked;
  int                visible_cnt;

  function new();
    foreach (coef_store[i]) coef_store[i] = '0;
    vp_x = '0; vp_y = '0; vp_w = 15'd1024; vp_h = 15'd768;
    errors = 0; checked = 0; visible_cnt = 0;
  endfunction

  function void set_reg(vppu_pkg::cfg_reg_t idx, logic [15:0] d);
    case (idx)
      vppu_pkg::REG_VP_X:      vp_x = d;
      vppu_pkg::REG_VP_Y:      vp_y = d;
      vppu_pkg::REG_VP_WIDTH:  vp_w = d[14:0];
      vppu_pkg::REG_VP_HEIGHT: vp_h = d[14:0];
      default: ;
    endcase
  endfunction

  // floor of v / 2^n; >>> on a signed value floors
  function longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void mat_mul(int base, longint src[4], output longint dst[4]);
    longint acc, c;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        c = longint'($signed(coef_store[base + k * 4 + r]));
        acc += fshift(c * src[k], 16);
      end
      dst[r] = clamp32(acc);
    end
  endfunction

  function longint to_win(longint org, longint sz, longint ndc);
    return clamp32(fshift(2 * org * 65536 + (65536 + ndc) * sz, 1));
  endfunction

  // Note an accepted input transaction
  function void note_input(vppu_pkg::op_t op, logic [4:0] idx, logic [31:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint o[4], e[4], cl[4];
    longint nx, ny, nz, wx, wy, wz, sy;
    point_t p;
    if (op == vppu_pkg::OP_LOAD) begin
      coef_store[idx] = val;
      return;
    end
    p = '{1'b0, 32'd0, 32'd0, 17'd0};
    o[0] = longint'($signed(x)); o[1] = longint'($signed(y));
    o[2] = longint'($signed(z)); o[3] = 65536;
    mat_mul(0, o, e);
    mat_mul(16, e, cl);
    if (cl[3] * 10000 >= 65536) begin
      nx = clamp32((cl[0] * 65536) / cl[3]);
      ny = clamp32((cl[1] * 65536) / cl[3]);
      nz = clamp32((cl[2] * 65536) / cl[3]);
      wx = to_win(longint'(vp_x), longint'(vp_w), nx);
      wy = to_win(longint'(vp_y), longint'(vp_h), ny);
      wz = fshift(65536 + nz, 1);
      if (wz >= 0 && wz <= 65536) begin
        sy = clamp32(longint'(vp_h) * 65536 - wy);
        p.visible  = 1'b1;
        p.screen_x = wx[31:0];
        p.screen_y = sy[31:0];
        p.depth    = wz[16:0];
      end
    end
    pending.push_back(p);
  endfunction

  // Compare an output transaction with the oldest expected point
  function void check_result(logic vis, logic [31:0] sx, logic [31:0] sy, logic [16:0] d);
    point_t p;
    if (pending.size() == 0) begin
      $display("%0t: unexpected point vis=%0b x=%h y=%h depth=%h", $time, vis, sx, sy, d);
      errors++;
      return;
    end
    p = pending.pop_front();
    checked++;
    if (vis) visible_cnt++;
    if (vis !== p.visible) begin
      $display("%0t: visible expected %0b actual %0b", $time, p.visible, vis); errors++;
    end
    if (sx !== p.screen_x) begin
      $display("%0t: screen_x expected %h actual %h", $time, p.screen_x, sx); errors++;
    end
    if (sy !== p.screen_y) begin
      $display("%0t: screen_y expected %h actual %h", $time, p.screen_y, sy); errors++;
    end
    if (d !== p.depth) begin
      $display("%0t: depth expected %h actual %h", $time, p.depth, d); errors++;
    end
  endfunction
endclass

module vertex_perspective_projection_unit_tb;
  import vppu_pkg::*;

  localparam int LATENCY     = 40;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [4:0]  coef_index = '0;
  word_t       coef_value = '0, obj_x = '0, obj_y = '0, obj_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        visible;
  word_t       screen_x, screen_y;
  logic [16:0] depth;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  projection_scoreboard sb = new();
  bit  quiet_phase = 0;   // no idling near the end
  bit  hold_sink = 0;     // long receiver hold-off
  int  idle_cycles = 0;
  int  items_sent = 0;

  always #2 clk = ~clk;

  vertex_perspective_projection_unit u_top (
    .clk, .rst, .in_valid, .in_ready, .op, .coef_index, .coef_value,
    .obj_x, .obj_y, .obj_z, .out_valid, .out_ready, .visible, .screen_x,
    .screen_y, .depth, .cfg_we, .cfg_index, .cfg_data
  );

  // Monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(op_t'(op), coef_index, coef_value, obj_x, obj_y, obj_z);
      if (out_valid && out_ready)
        sb.check_result(visible, screen_x, screen_y, depth);
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("vertex_perspective_projection_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when asked
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 20);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Send one transaction, with an optional idle burst before it
  task automatic send(op_t o, logic [4:0] idx, word_t val, word_t x, word_t y, word_t z);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o; coef_index <= idx; coef_value <= val;
    obj_x <= x; obj_y <= y; obj_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load(logic [4:0] idx, word_t val);
    send(OP_LOAD, idx, val, word_t'($urandom), word_t'($urandom), word_t'($urandom));
  endtask

  task automatic project(word_t x, word_t y, word_t z);
    send(OP_PROJECT, 5'($urandom), word_t'($urandom), x, y, z);
  endtask

  // Drain and write a viewport register while idle
  task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  // A well-formed projection setup: near-identity modelview, perspective-like projection
  task automatic load_sane_matrices();
    for (int i = 0; i < 32; i++) load(5'(i), 0);
    load(5'd0, 32'h10000 + $urandom_range(0, 8191) - 4096);
    load(5'd5, 32'h10000);
    load(5'd10, 32'h10000);
    load(5'd15, 32'h10000);
    load(5'd12, $urandom_range(0, 262143) - 131072);
    load(5'd14, -($urandom_range(131072, 655360)));
    load(5'd16, 32'h10000);
    load(5'd21, 32'h10000);
    load(5'd26, -32'h10000 - $urandom_range(0, 4096));
    load(5'd27, -32'h10000);
    load(5'd30, -($urandom_range(0, 65536)));
  endtask

  function automatic word_t rnd_word();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return word_t'($urandom);
      default: return word_t'($urandom_range(0, 1048576)) - 524288;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cleared store gives w = 0, rejected
    project(0, 0, 0);
    project(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    // Identity matrices: w = 1.0, depth at and beyond the edges
    load(5'd0, 32'h10000); load(5'd5, 32'h10000);
    load(5'd10, 32'h10000); load(5'd15, 32'h10000);
    load(5'd16, 32'h10000); load(5'd21, 32'h10000);
    load(5'd26, 32'h10000); load(5'd31, 32'h10000);
    project(0, 0, 0);
    project(32'h10000, -32'h10000, 32'h10000);
    project(0, 0, -32'h10000);
    project(0, 0, 32'h10001);
    project(0, 0, -32'h10001);
    project(32'sh7fffffff, 32'sh80000000, 0);
    // w just above and below the threshold
    load(5'd31, 32'd7); project(0, 0, 0);
    load(5'd31, 32'd6); project(0, 0, 0);
    load(5'd31, -32'h10000); project(0, 0, 0);
    load(5'd31, 32'h10000);
    // Saturating coefficients
    load(5'd0, 32'sh7fffffff); load(5'd16, 32'sh80000000);
    project(32'sh7fffffff, 0, 0);

    // Viewport extremes and random settings across phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_VP_X, 16'h7fff); write_reg(REG_VP_Y, 16'h8000);
          write_reg(REG_VP_WIDTH, 16'h7fff); write_reg(REG_VP_HEIGHT, 16'h7fff);
        end
        1: begin
          write_reg(REG_VP_X, 16'h8000); write_reg(REG_VP_Y, 16'h7fff);
          write_reg(REG_VP_WIDTH, 16'h0); write_reg(REG_VP_HEIGHT, 16'h0);
        end
        default: begin
          write_reg(REG_VP_X, 16'($urandom)); write_reg(REG_VP_Y, 16'($urandom));
          write_reg(REG_VP_WIDTH, 16'($urandom)); write_reg(REG_VP_HEIGHT, 16'($urandom));
        end
      endcase
      if (ph == 3) hold_sink = 1;
      if (ph == 7) quiet_phase = 1;
      if ($urandom_range(0, 3) != 0) load_sane_matrices();
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(0, 9) == 0)
          load(5'($urandom), rnd_word());
        else if ($urandom_range(0, 5) == 0)
          project(rnd_word(), rnd_word(), rnd_word());
        else
          project($urandom_range(0, 524288) - 262144, $urandom_range(0, 524288) - 262144,
                  $urandom_range(0, 524288) - 262144);
      end
    end

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d transactions; checked %0d points, %0d visible.",
             items_sent, sb.checked, sb.visible_cnt);
    $display("Viewport covered extremes and random settings, with long output stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("vertex_perspective_projection_unit regression: pass");
    end else begin
      $display("vertex_perspective_projection_unit regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: sim.f
sv/vppu_pkg.sv
sv/vppu_xform.sv
sv/vppu_div.sv
sv/vppu_window.sv
sv/vertex_perspective_projection_unit.sv
verif/vertex_perspective_projection_unit_tb.sv
